[rtl/stk_pkg.sv]
package stk_pkg;

    localparam int PAGE_BYTES_DEF = 128;

    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_RX    = 3'd1;
    localparam logic [2:0] K_TX    = 3'd2;
    localparam logic [2:0] K_IMG   = 3'd3;
    localparam logic [2:0] K_TICK  = 3'd4;

    localparam logic [2:0] E_SEND  = 3'd0;
    localparam logic [2:0] E_REQ   = 3'd1;
    localparam logic [2:0] E_RST   = 3'd2;
    localparam logic [2:0] E_BAUD  = 3'd3;
    localparam logic [2:0] E_DONE  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSYNC  = 3'd1;
    localparam logic [2:0] ST_PROGREF = 3'd2;
    localparam logic [2:0] ST_WRFAIL  = 3'd3;
    localparam logic [2:0] ST_VFYFAIL = 3'd4;

    localparam logic [7:0] B_OK       = 8'h10;
    localparam logic [7:0] B_INSYNC   = 8'h14;
    localparam logic [7:0] B_EOP      = 8'h20;
    localparam logic [7:0] B_GET_SYNC = 8'h30;
    localparam logic [7:0] B_ENTER    = 8'h50;
    localparam logic [7:0] B_LEAVE    = 8'h51;
    localparam logic [7:0] B_LOAD     = 8'h55;
    localparam logic [7:0] B_PROG     = 8'h64;
    localparam logic [7:0] B_READ     = 8'h74;
    localparam logic [7:0] B_FLASH    = 8'h46;
    localparam logic [7:0] B_PAD      = 8'hFF;

    localparam logic [11:0] T_SETTLE   = 12'd5;
    localparam logic [11:0] T_RST_HOLD = 12'd70;
    localparam logic [11:0] T_RST_GAP  = 12'd35;
    localparam logic [11:0] T_SYNC_WIN = 12'd180;
    localparam logic [11:0] T_SYNC_GAP = 12'd35;
    localparam logic [11:0] T_OK_WIN   = 12'd250;
    localparam logic [11:0] T_PROG_WIN = 12'd1800;
    localparam logic [11:0] T_READ_WIN = 12'd1200;
    localparam logic [11:0] T_BYTE_WIN = 12'd500;
    localparam logic [3:0]  SYNC_TRIES = 4'd12;

    localparam logic [1:0] A_LEN  = 2'd0;
    localparam logic [1:0] A_TMO  = 2'd1;
    localparam logic [1:0] A_SEC  = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_SETTLE, PH_RST_HOLD, PH_RST_GAP, PH_SYNC_GAP, PH_FILL,
        PH_SEND, PH_WAIT, PH_RD_INSYNC, PH_RD_DATA, PH_RD_OK
    } t_phase;

    typedef enum logic [2:0] {
        C_SYNC, C_ENTER, C_LOAD1, C_PROG, C_LOAD2, C_READ, C_LEAVE
    } t_cmd;

    typedef enum logic [1:0] {
        S_IN, S_MEM, S_OUT
    } t_seq;

    typedef struct packed {
        logic [14:0] image_length;
        logic [11:0] reply_timeout_ms;
        logic        secondary_baud_enabled;
    } t_cfg;

endpackage

[rtl/stk_if.sv]
interface stk_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    modport source (output valid, kind, value, input ready);
    modport sink (input valid, kind, value, output ready);
endinterface

interface stk_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  byte_out;
    logic        reset_asserted;
    logic        baud_secondary;
    logic [2:0]  status;
    logic [14:0] fail_offset;
    modport source (output valid, event_res, byte_out, reset_asserted, baud_secondary,
                    status, fail_offset, input ready);
    modport sink (input valid, event_res, byte_out, reset_asserted, baud_secondary,
                  status, fail_offset, output ready);
endinterface

[rtl/stk_cfg.sv]
module stk_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output stk_pkg::t_cfg o_cfg
);
    stk_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_length           <= 15'd1;
            r_cfg.reply_timeout_ms       <= 12'd500;
            r_cfg.secondary_baud_enabled <= 1'b1;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            if (paddr[3:2] == stk_pkg::A_LEN) r_cfg.image_length <= pwdata[14:0];
            if (paddr[3:2] == stk_pkg::A_TMO) r_cfg.reply_timeout_ms <= pwdata[11:0];
            if (paddr[3:2] == stk_pkg::A_SEC) r_cfg.secondary_baud_enabled <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            stk_pkg::A_LEN: prdata = {17'd0, r_cfg.image_length};
            stk_pkg::A_TMO: prdata = {20'd0, r_cfg.reply_timeout_ms};
            stk_pkg::A_SEC: prdata = {31'd0, r_cfg.secondary_baud_enabled};
            default:        prdata = '0;
        endcase
    end
endmodule

[rtl/stk_pbuf.sv]
module stk_pbuf #(
    parameter int PAGE_BYTES = stk_pkg::PAGE_BYTES_DEF,
    localparam int AW = $clog2(PAGE_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [PAGE_BYTES+1];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/stk500_page_programmer.sv]
// channel   dir  payload
// i_in      in   kind[3], value[8]
// o_out     out  event_res, byte_out, reset_asserted, baud_secondary, status, fail_offset
// apb       in   image_length @0x0, reply_timeout_ms @0x4, secondary_baud_enabled @0x8
// an item is taken in S_IN and processed in S_MEM: the accept edge also clocks the page
// buffer read (registered memory), and S_MEM updates the state and loads the result register
// next item is accepted once the result register is free or being taken
// reset clears control state; page buffer is not cleared
// a stalled result holds its register and blocks further input
module stk500_page_programmer #(
    parameter int PAGE_BYTES = stk_pkg::PAGE_BYTES_DEF,
    localparam int AW = $clog2(PAGE_BYTES + 1),
    localparam int LW = $clog2(PAGE_BYTES + 2)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stk_in_if.sink      i_in,
    stk_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    stk_pkg::t_cfg   w_cfg;
    stk_pkg::t_phase r_phase, n_phase;
    stk_pkg::t_cmd   r_cmd, n_cmd;
    stk_pkg::t_seq   r_seq;
    logic [2:0]  r_kind;
    logic [7:0]  r_val;
    logic [14:0] r_off, n_off;
    logic [LW-1:0] r_fill, n_fill, r_plen, n_plen, r_cidx, n_cidx;
    logic [8:0]  r_cmdi, n_cmdi;
    logic [11:0] r_tmr, n_tmr;
    logic [3:0]  r_att, n_att;
    logic r_ins, n_ins, r_sec, n_sec, r_rst, n_rst;
    logic        r_ov, n_emit;
    logic [2:0]  r_ev, n_ev, r_st, n_st;
    logic [7:0]  r_byte, n_byte;
    logic [14:0] r_foff, n_foff;
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]  w_wdata, w_rdata;
    logic        w_take;

    stk_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_cfg(w_cfg)
    );

    stk_pbuf #(.PAGE_BYTES(PAGE_BYTES)) u_buf (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign i_in.ready = (r_seq == stk_pkg::S_IN) && (!r_ov || o_out.ready);
    assign w_take = i_in.valid && i_in.ready;
    assign o_out.valid = r_ov;
    assign o_out.event_res = r_ev;
    assign o_out.byte_out = r_byte;
    assign o_out.reset_asserted = r_rst;
    assign o_out.baud_secondary = r_sec;
    assign o_out.status = r_st;
    assign o_out.fail_offset = r_foff;

    // read address for this item: data byte for send or compare
    always_comb begin
        w_raddr = r_cidx[AW-1:0];
        if (r_phase == stk_pkg::PH_SEND) w_raddr = AW'(r_cmdi - 9'd4);
    end

    logic [8:0] w_clen;
    always_comb begin
        unique case (r_cmd)
            stk_pkg::C_LOAD1, stk_pkg::C_LOAD2: w_clen = 9'd4;
            stk_pkg::C_PROG: w_clen = 9'd5 + 9'(r_plen);
            stk_pkg::C_READ: w_clen = 9'd5;
            default: w_clen = 9'd2;
        endcase
    end

    // main update, done in S_MEM when buffer data is ready
    always_comb begin
        logic [15:0] addr;
        logic        good, bad, expired;
        logic [14:0] off2;
        n_phase = r_phase; n_cmd = r_cmd; n_off = r_off; n_fill = r_fill;
        n_plen = r_plen; n_cidx = r_cidx; n_cmdi = r_cmdi; n_tmr = r_tmr;
        n_att = r_att; n_ins = r_ins; n_sec = r_sec; n_rst = r_rst;
        n_emit = 1'b0; n_ev = stk_pkg::E_SEND; n_byte = '0; n_st = stk_pkg::ST_OK;
        n_foff = '0; w_we = 1'b0; w_waddr = r_fill[AW-1:0]; w_wdata = r_val;
        good = 1'b0; bad = 1'b0; expired = 1'b0;
        addr = {2'b0, r_off[14:1]};
        off2 = r_off;
        if (r_seq == stk_pkg::S_MEM) begin
            unique case (r_kind)
                stk_pkg::K_START: begin
                    n_off = '0; n_fill = '0; n_plen = '0; n_cmdi = '0; n_cidx = '0;
                    n_att = '0; n_ins = 1'b0; n_sec = 1'b0; n_rst = 1'b0;
                    n_phase = stk_pkg::PH_SETTLE; n_tmr = stk_pkg::T_SETTLE;
                    n_emit = 1'b1; n_ev = stk_pkg::E_BAUD;
                end
                stk_pkg::K_RX: begin
                    priority case (r_phase)
                        stk_pkg::PH_WAIT: begin
                            if (!r_ins) begin
                                if (r_val == stk_pkg::B_INSYNC) begin
                                    n_ins = 1'b1; n_tmr = stk_pkg::T_OK_WIN;
                                end
                            end else begin
                                n_ins = 1'b0;
                                if (r_val == stk_pkg::B_OK) good = 1'b1; else bad = 1'b1;
                            end
                        end
                        stk_pkg::PH_RD_INSYNC: begin
                            if (r_val != stk_pkg::B_INSYNC) bad = 1'b1;
                            else begin
                                n_cidx = '0; n_tmr = stk_pkg::T_BYTE_WIN;
                                n_phase = (r_plen == '0) ? stk_pkg::PH_RD_OK
                                                         : stk_pkg::PH_RD_DATA;
                            end
                        end
                        stk_pkg::PH_RD_DATA: begin
                            if (r_cidx > LW'(PAGE_BYTES) || r_val != w_rdata) bad = 1'b1;
                            else begin
                                n_cidx = r_cidx + 1'b1; n_tmr = stk_pkg::T_BYTE_WIN;
                                if (n_cidx >= r_plen) n_phase = stk_pkg::PH_RD_OK;
                            end
                        end
                        stk_pkg::PH_RD_OK: begin
                            if (r_val == stk_pkg::B_OK) good = 1'b1; else bad = 1'b1;
                        end
                        default: ;
                    endcase
                end
                stk_pkg::K_TX: begin
                    if (r_phase == stk_pkg::PH_SEND) begin
                        n_emit = 1'b1;
                        if (r_cmdi >= w_clen - 9'd1) n_byte = stk_pkg::B_EOP;
                        else begin
                            unique case (r_cmd)
                                stk_pkg::C_SYNC:  n_byte = stk_pkg::B_GET_SYNC;
                                stk_pkg::C_ENTER: n_byte = stk_pkg::B_ENTER;
                                stk_pkg::C_LEAVE: n_byte = stk_pkg::B_LEAVE;
                                stk_pkg::C_LOAD1, stk_pkg::C_LOAD2:
                                    n_byte = (r_cmdi == 9'd0) ? stk_pkg::B_LOAD :
                                             (r_cmdi == 9'd1) ? addr[7:0] : addr[15:8];
                                default: begin
                                    if (r_cmdi == 9'd0)
                                        n_byte = (r_cmd == stk_pkg::C_PROG) ? stk_pkg::B_PROG
                                                                            : stk_pkg::B_READ;
                                    else if (r_cmdi == 9'd1) n_byte = 8'(r_plen >> 8);
                                    else if (r_cmdi == 9'd2) n_byte = r_plen[7:0];
                                    else if (r_cmdi == 9'd3) n_byte = stk_pkg::B_FLASH;
                                    else if (r_cmdi - 9'd4 < 9'(PAGE_BYTES + 1))
                                        n_byte = w_rdata;
                                    else n_byte = stk_pkg::B_PAD;
                                end
                            endcase
                        end
                        n_cmdi = r_cmdi + 9'd1;
                        if (n_cmdi >= w_clen) begin
                            n_ins = 1'b0;
                            if (r_cmd == stk_pkg::C_READ) begin
                                n_phase = stk_pkg::PH_RD_INSYNC; n_tmr = stk_pkg::T_READ_WIN;
                            end else begin
                                n_phase = stk_pkg::PH_WAIT;
                                n_tmr = (r_cmd == stk_pkg::C_SYNC) ? stk_pkg::T_SYNC_WIN :
                                        (r_cmd == stk_pkg::C_PROG) ? stk_pkg::T_PROG_WIN :
                                        w_cfg.reply_timeout_ms;
                            end
                        end
                    end
                end
                stk_pkg::K_IMG: begin
                    if (r_phase == stk_pkg::PH_FILL) begin
                        w_we = (r_fill <= LW'(PAGE_BYTES));
                        n_fill = r_fill + 1'b1;
                        if (n_fill < r_plen) begin
                            n_emit = 1'b1; n_ev = stk_pkg::E_REQ;
                        end else begin
                            // odd page: pad entry was written when the page was requested
                            if (r_plen[0]) n_plen = r_plen + 1'b1;
                            n_cmd = stk_pkg::C_LOAD1; n_cmdi = '0;
                            n_phase = stk_pkg::PH_SEND;
                        end
                    end
                end
                stk_pkg::K_TICK: begin
                    if (r_phase != stk_pkg::PH_IDLE && r_phase != stk_pkg::PH_FILL &&
                        r_phase != stk_pkg::PH_SEND) begin
                        expired = (r_tmr <= 12'd1);
                        n_tmr = expired ? 12'd0 : r_tmr - 12'd1;
                    end
                    if (expired) begin
                        priority case (r_phase)
                            stk_pkg::PH_SETTLE: begin
                                n_rst = 1'b1; n_phase = stk_pkg::PH_RST_HOLD;
                                n_tmr = stk_pkg::T_RST_HOLD;
                                n_emit = 1'b1; n_ev = stk_pkg::E_RST;
                            end
                            stk_pkg::PH_RST_HOLD: begin
                                n_rst = 1'b0; n_phase = stk_pkg::PH_RST_GAP;
                                n_tmr = stk_pkg::T_RST_GAP;
                                n_emit = 1'b1; n_ev = stk_pkg::E_RST;
                            end
                            stk_pkg::PH_RST_GAP: begin
                                n_cmd = stk_pkg::C_SYNC; n_cmdi = '0;
                                n_phase = stk_pkg::PH_SEND;
                            end
                            stk_pkg::PH_SYNC_GAP: begin
                                if (r_att < stk_pkg::SYNC_TRIES) begin
                                    n_cmd = stk_pkg::C_SYNC; n_cmdi = '0;
                                    n_phase = stk_pkg::PH_SEND;
                                end else if (w_cfg.secondary_baud_enabled && !r_sec) begin
                                    n_sec = 1'b1; n_att = '0;
                                    n_phase = stk_pkg::PH_SETTLE; n_tmr = stk_pkg::T_SETTLE;
                                    n_emit = 1'b1; n_ev = stk_pkg::E_BAUD;
                                end else begin
                                    n_phase = stk_pkg::PH_IDLE; n_emit = 1'b1;
                                    n_ev = stk_pkg::E_DONE; n_st = stk_pkg::ST_NOSYNC;
                                end
                            end
                            default: begin
                                n_ins = 1'b0; bad = 1'b1;
                            end
                        endcase
                    end
                end
                default: ;
            endcase

            if (good) begin
                priority case (r_cmd)
                    stk_pkg::C_SYNC: begin
                        n_cmd = stk_pkg::C_ENTER; n_cmdi = '0; n_phase = stk_pkg::PH_SEND;
                    end
                    stk_pkg::C_LOAD1: begin
                        n_cmd = stk_pkg::C_PROG; n_cmdi = '0; n_phase = stk_pkg::PH_SEND;
                    end
                    stk_pkg::C_PROG: begin
                        n_cmd = stk_pkg::C_LOAD2; n_cmdi = '0; n_phase = stk_pkg::PH_SEND;
                    end
                    stk_pkg::C_LOAD2: begin
                        n_cmd = stk_pkg::C_READ; n_cmdi = '0; n_phase = stk_pkg::PH_SEND;
                    end
                    stk_pkg::C_LEAVE: begin
                        n_phase = stk_pkg::PH_IDLE; n_emit = 1'b1; n_ev = stk_pkg::E_DONE;
                    end
                    default: begin
                        if (r_cmd == stk_pkg::C_READ) off2 = r_off + 15'(r_fill);
                        n_off = off2;
                        if (off2 < w_cfg.image_length) begin
                            n_plen = ((w_cfg.image_length - off2) > 15'(PAGE_BYTES)) ?
                                     LW'(PAGE_BYTES) : LW'(w_cfg.image_length - off2);
                            n_fill = '0; n_phase = stk_pkg::PH_FILL;
                            n_emit = 1'b1; n_ev = stk_pkg::E_REQ;
                            // odd page: the pad goes into the entry after the data
                            if (n_plen[0]) begin
                                w_we = 1'b1; w_waddr = n_plen[AW-1:0];
                                w_wdata = stk_pkg::B_PAD;
                            end
                        end else begin
                            n_cmd = stk_pkg::C_LEAVE; n_cmdi = '0;
                            n_phase = stk_pkg::PH_SEND;
                        end
                    end
                endcase
            end
            if (bad) begin
                priority case (r_cmd)
                    stk_pkg::C_SYNC: begin
                        n_att = r_att + 1'b1; n_phase = stk_pkg::PH_SYNC_GAP;
                        n_tmr = stk_pkg::T_SYNC_GAP;
                    end
                    default: begin
                        n_phase = stk_pkg::PH_IDLE; n_emit = 1'b1; n_ev = stk_pkg::E_DONE;
                        if (r_cmd == stk_pkg::C_ENTER) n_st = stk_pkg::ST_PROGREF;
                        else if (r_cmd == stk_pkg::C_LOAD1 || r_cmd == stk_pkg::C_PROG) begin
                            n_st = stk_pkg::ST_WRFAIL; n_foff = r_off;
                        end else if (r_cmd == stk_pkg::C_LOAD2 || r_cmd == stk_pkg::C_READ)
                        begin
                            n_st = stk_pkg::ST_VFYFAIL; n_foff = r_off;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= stk_pkg::S_IN; r_phase <= stk_pkg::PH_IDLE; r_cmd <= stk_pkg::C_SYNC;
            r_off <= '0; r_fill <= '0; r_plen <= '0; r_cidx <= '0; r_cmdi <= '0;
            r_tmr <= '0; r_att <= '0; r_ins <= 1'b0; r_sec <= 1'b0; r_rst <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && o_out.ready) r_ov <= 1'b0;
            unique case (r_seq)
                stk_pkg::S_IN: if (w_take) r_seq <= stk_pkg::S_MEM;
                stk_pkg::S_MEM: begin
                    r_seq <= stk_pkg::S_IN;
                    r_phase <= n_phase; r_cmd <= n_cmd; r_off <= n_off; r_fill <= n_fill;
                    r_plen <= n_plen; r_cidx <= n_cidx; r_cmdi <= n_cmdi; r_tmr <= n_tmr;
                    r_att <= n_att; r_ins <= n_ins; r_sec <= n_sec; r_rst <= n_rst;
                    if (n_emit) r_ov <= 1'b1;
                end
                default: r_seq <= stk_pkg::S_IN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= i_in.kind; r_val <= i_in.value;
        end
        if (r_seq == stk_pkg::S_MEM && n_emit) begin
            r_ev <= n_ev; r_byte <= n_byte; r_st <= n_st; r_foff <= n_foff;
        end
    end

    a_no_emit_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == stk_pkg::S_MEM) |-> (!r_ov))
        else $error("result overwritten");
    a_one_cycle_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == stk_pkg::S_MEM) |=> (r_seq == stk_pkg::S_IN))
        else $error("sequencer stuck");
    a_take_only_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_seq == stk_pkg::S_MEM))
        else $error("accept not processed");
endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  b;
        logic        rst;
        logic        baud;
        logic [2:0]  st;
        logic [14:0] off;
    } t_ev;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] value;
        bit         typed;
        t_ev        want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stk_in_if  in_ch ();
    stk_out_if out_ch ();

    stk500_page_programmer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // shadow of the programmer
    logic [14:0]     cfg_len;
    logic [11:0]     cfg_tmo;
    logic            cfg_sec;
    stk_pkg::t_phase ph;
    stk_pkg::t_cmd   cmd;
    logic [7:0]      pbuf [0:stk_pkg::PAGE_BYTES_DEF];
    int          img_off, fill_cnt, pg_len, cmd_idx, cmp_idx, wtimer, tries;
    bit          insync, on_sec, rst_lvl;

    t_ev pending_events [$];
    int  errors = 0, checked = 0, items = 0, rand_items = 0, sessions = 0;
    int  fin_seen [0:7];
    bit  calm = 1'b0;

    function automatic t_ev mk(input logic [2:0] e, input logic [7:0] b,
                               input logic [2:0] st, input logic [14:0] off);
        t_ev r;
        r.ev = e; r.b = b; r.rst = rst_lvl; r.baud = on_sec; r.st = st; r.off = off;
        return r;
    endfunction

    function automatic t_ev finish_run(input logic [2:0] st, input logic [14:0] off);
        ph = stk_pkg::PH_IDLE;
        return mk(stk_pkg::E_DONE, 8'h00, st, off);
    endfunction

    function automatic bit timer_out();
        if (wtimer <= 1) begin
            wtimer = 0;
            return 1'b1;
        end
        wtimer--;
        return 1'b0;
    endfunction

    function automatic void begin_cmd(input stk_pkg::t_cmd c);
        cmd = c;
        cmd_idx = 0;
        ph = stk_pkg::PH_SEND;
    endfunction

    function automatic int cmd_len();
        case (cmd)
            stk_pkg::C_LOAD1, stk_pkg::C_LOAD2: return 4;
            stk_pkg::C_PROG: return 5 + pg_len;
            stk_pkg::C_READ: return 5;
            default: return 2;
        endcase
    endfunction

    function automatic logic [7:0] cmd_byte(input int i);
        logic [15:0] addr;
        addr = 16'(img_off >> 1);
        if (i >= cmd_len() - 1) return stk_pkg::B_EOP;
        case (cmd)
            stk_pkg::C_SYNC: return stk_pkg::B_GET_SYNC;
            stk_pkg::C_ENTER: return stk_pkg::B_ENTER;
            stk_pkg::C_LEAVE: return stk_pkg::B_LEAVE;
            stk_pkg::C_LOAD1, stk_pkg::C_LOAD2: begin
                if (i == 0) return stk_pkg::B_LOAD;
                return i == 1 ? addr[7:0] : addr[15:8];
            end
            default: begin
                if (i == 0) return cmd == stk_pkg::C_PROG ? stk_pkg::B_PROG : stk_pkg::B_READ;
                if (i == 1) return 8'(pg_len >> 8);
                if (i == 2) return 8'(pg_len);
                if (i == 3) return stk_pkg::B_FLASH;
                return (i - 4) <= stk_pkg::PAGE_BYTES_DEF ? pbuf[i - 4] : stk_pkg::B_PAD;
            end
        endcase
    endfunction

    function automatic bit next_page(output t_ev r);
        int wanted;
        if (img_off < cfg_len) begin
            wanted = cfg_len - img_off;
            if (wanted > stk_pkg::PAGE_BYTES_DEF) wanted = stk_pkg::PAGE_BYTES_DEF;
            pg_len = wanted;
            fill_cnt = 0;
            ph = stk_pkg::PH_FILL;
            r = mk(stk_pkg::E_REQ, 8'h00, stk_pkg::ST_OK, 15'd0);
            return 1'b1;
        end
        begin_cmd(stk_pkg::C_LEAVE);
        return 1'b0;
    endfunction

    function automatic bit reply_good(output t_ev r);
        case (cmd)
            stk_pkg::C_SYNC: begin begin_cmd(stk_pkg::C_ENTER); return 1'b0; end
            stk_pkg::C_ENTER: return next_page(r);
            stk_pkg::C_LOAD1: begin begin_cmd(stk_pkg::C_PROG); return 1'b0; end
            stk_pkg::C_PROG: begin begin_cmd(stk_pkg::C_LOAD2); return 1'b0; end
            stk_pkg::C_LOAD2: begin begin_cmd(stk_pkg::C_READ); return 1'b0; end
            stk_pkg::C_READ: begin
                img_off = (img_off + fill_cnt) & 32'h7FFF;
                return next_page(r);
            end
            default: begin r = finish_run(stk_pkg::ST_OK, 15'd0); return 1'b1; end
        endcase
    endfunction

    function automatic bit reply_bad(output t_ev r);
        case (cmd)
            stk_pkg::C_SYNC: begin
                tries++;
                ph = stk_pkg::PH_SYNC_GAP;
                wtimer = stk_pkg::T_SYNC_GAP;
                return 1'b0;
            end
            stk_pkg::C_ENTER: r = finish_run(stk_pkg::ST_PROGREF, 15'd0);
            stk_pkg::C_LOAD1, stk_pkg::C_PROG: r = finish_run(stk_pkg::ST_WRFAIL, 15'(img_off));
            stk_pkg::C_LOAD2, stk_pkg::C_READ:
                r = finish_run(stk_pkg::ST_VFYFAIL, 15'(img_off));
            default: r = finish_run(stk_pkg::ST_OK, 15'd0);
        endcase
        return 1'b1;
    endfunction

    function automatic bit predict_step(input logic [2:0] kind, input logic [7:0] v,
                                        output t_ev r);
        logic [7:0] b;
        case (kind)
            stk_pkg::K_START: begin
                img_off = 0; fill_cnt = 0; pg_len = 0; cmd_idx = 0; cmp_idx = 0;
                tries = 0; insync = 0; on_sec = 0; rst_lvl = 0;
                ph = stk_pkg::PH_SETTLE;
                wtimer = stk_pkg::T_SETTLE;
                r = mk(stk_pkg::E_BAUD, 8'h00, stk_pkg::ST_OK, 15'd0);
                return 1'b1;
            end
            stk_pkg::K_RX: case (ph)
                stk_pkg::PH_WAIT: begin
                    if (!insync) begin
                        if (v == stk_pkg::B_INSYNC) begin
                            insync = 1;
                            wtimer = stk_pkg::T_OK_WIN;
                        end
                        return 1'b0;
                    end
                    insync = 0;
                    return v == stk_pkg::B_OK ? reply_good(r) : reply_bad(r);
                end
                stk_pkg::PH_RD_INSYNC: begin
                    if (v != stk_pkg::B_INSYNC) return reply_bad(r);
                    cmp_idx = 0;
                    wtimer = stk_pkg::T_BYTE_WIN;
                    ph = pg_len == 0 ? stk_pkg::PH_RD_OK : stk_pkg::PH_RD_DATA;
                    return 1'b0;
                end
                stk_pkg::PH_RD_DATA: begin
                    if (cmp_idx > stk_pkg::PAGE_BYTES_DEF || v != pbuf[cmp_idx])
                        return reply_bad(r);
                    cmp_idx++;
                    wtimer = stk_pkg::T_BYTE_WIN;
                    if (cmp_idx >= pg_len) ph = stk_pkg::PH_RD_OK;
                    return 1'b0;
                end
                stk_pkg::PH_RD_OK: return v == stk_pkg::B_OK ? reply_good(r) : reply_bad(r);
                default: return 1'b0;
            endcase
            stk_pkg::K_TX: begin
                if (ph != stk_pkg::PH_SEND) return 1'b0;
                b = cmd_byte(cmd_idx);
                cmd_idx++;
                if (cmd_idx >= cmd_len()) begin
                    insync = 0;
                    if (cmd == stk_pkg::C_READ) begin
                        ph = stk_pkg::PH_RD_INSYNC;
                        wtimer = stk_pkg::T_READ_WIN;
                    end else begin
                        ph = stk_pkg::PH_WAIT;
                        wtimer = cmd == stk_pkg::C_SYNC ? stk_pkg::T_SYNC_WIN :
                                 cmd == stk_pkg::C_PROG ? stk_pkg::T_PROG_WIN : cfg_tmo;
                    end
                end
                r = mk(stk_pkg::E_SEND, b, stk_pkg::ST_OK, 15'd0);
                return 1'b1;
            end
            stk_pkg::K_IMG: begin
                if (ph != stk_pkg::PH_FILL) return 1'b0;
                if (fill_cnt <= stk_pkg::PAGE_BYTES_DEF) pbuf[fill_cnt] = v;
                fill_cnt++;
                if (fill_cnt < pg_len) begin
                    r = mk(stk_pkg::E_REQ, 8'h00, stk_pkg::ST_OK, 15'd0);
                    return 1'b1;
                end
                // odd page gets a pad byte
                if (pg_len % 2) begin
                    if (pg_len <= stk_pkg::PAGE_BYTES_DEF) pbuf[pg_len] = stk_pkg::B_PAD;
                    pg_len++;
                end
                begin_cmd(stk_pkg::C_LOAD1);
                return 1'b0;
            end
            stk_pkg::K_TICK: case (ph)
                stk_pkg::PH_SETTLE: begin
                    if (!timer_out()) return 1'b0;
                    rst_lvl = 1;
                    ph = stk_pkg::PH_RST_HOLD;
                    wtimer = stk_pkg::T_RST_HOLD;
                    r = mk(stk_pkg::E_RST, 8'h00, stk_pkg::ST_OK, 15'd0);
                    return 1'b1;
                end
                stk_pkg::PH_RST_HOLD: begin
                    if (!timer_out()) return 1'b0;
                    rst_lvl = 0;
                    ph = stk_pkg::PH_RST_GAP;
                    wtimer = stk_pkg::T_RST_GAP;
                    r = mk(stk_pkg::E_RST, 8'h00, stk_pkg::ST_OK, 15'd0);
                    return 1'b1;
                end
                stk_pkg::PH_RST_GAP: begin
                    if (timer_out()) begin_cmd(stk_pkg::C_SYNC);
                    return 1'b0;
                end
                stk_pkg::PH_SYNC_GAP: begin
                    if (!timer_out()) return 1'b0;
                    if (tries < stk_pkg::SYNC_TRIES) begin
                        begin_cmd(stk_pkg::C_SYNC);
                        return 1'b0;
                    end
                    if (cfg_sec && !on_sec) begin
                        on_sec = 1;
                        tries = 0;
                        ph = stk_pkg::PH_SETTLE;
                        wtimer = stk_pkg::T_SETTLE;
                        r = mk(stk_pkg::E_BAUD, 8'h00, stk_pkg::ST_OK, 15'd0);
                        return 1'b1;
                    end
                    r = finish_run(stk_pkg::ST_NOSYNC, 15'd0);
                    return 1'b1;
                end
                stk_pkg::PH_WAIT, stk_pkg::PH_RD_INSYNC, stk_pkg::PH_RD_DATA,
                stk_pkg::PH_RD_OK: begin
                    if (!timer_out()) return 1'b0;
                    insync = 0;
                    return reply_bad(r);
                end
                default: return 1'b0;
            endcase
            default: return 1'b0;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_ev got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.event_res, out_ch.byte_out, out_ch.reset_asserted,
                   out_ch.baud_secondary, out_ch.status, out_ch.fail_offset};
            checked++;
            if (got.ev == stk_pkg::E_DONE) fin_seen[got.st]++;
            if (pending_events.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: ev %0d byte %02h", got.ev, got.b);
            end else begin
                want = pending_events.pop_front();
                if (got.ev !== want.ev || got.b !== want.b || got.rst !== want.rst ||
                    got.baud !== want.baud || got.st !== want.st || got.off !== want.off) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp ev %0d b %02h rst %0d baud %0d st %0d off %0d",
                                 want.ev, want.b, want.rst, want.baud, want.st, want.off);
                        $display("          got ev %0d b %02h rst %0d baud %0d st %0d off %0d",
                                 got.ev, got.b, got.rst, got.baud, got.st, got.off);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 16);
    end

    task automatic send_item(input logic [2:0] k, input logic [7:0] v,
                             input bit typed = 1'b0, input t_ev want = '0);
        t_ev r;
        bit has;
        if (!calm && $urandom_range(99) < 16) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= k;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        has = predict_step(k, v, r);
        if (typed) pending_events.push_back(want);
        else if (has) pending_events.push_back(r);
        items++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            stk_pkg::A_LEN: cfg_len = data[14:0];
            stk_pkg::A_TMO: cfg_tmo = data[11:0];
            default: cfg_sec = data[0];
        endcase
    endtask

    // one programming session: answers follow the shadow state, with faults mixed in
    // doom_sync makes every sync try at the primary baud fail
    task automatic run_session(input int len, input int tmo, input bit sec,
                               input int fault_pm, input bit doom_sync, input int cap);
        int n;
        bit bad;
        logic [2:0] k;
        logic [7:0] v;
        drain();
        write_reg(stk_pkg::A_LEN, len);
        write_reg(stk_pkg::A_TMO, tmo);
        write_reg(stk_pkg::A_SEC, sec);
        sessions++;
        send_item(stk_pkg::K_START, 8'($urandom));
        n = 0;
        while (ph != stk_pkg::PH_IDLE) begin
            bad = (n > cap) || ($urandom_range(999) < fault_pm);
            k = stk_pkg::K_TICK;
            v = 8'($urandom);
            if (n <= cap && $urandom_range(99) < 3) begin
                k = 3'($urandom_range(1, 7));
            end else case (ph)
                stk_pkg::PH_FILL: k = stk_pkg::K_IMG;
                stk_pkg::PH_SEND: k = stk_pkg::K_TX;
                stk_pkg::PH_WAIT: if ($urandom_range(99) >= 4) begin
                    k = stk_pkg::K_RX;
                    if (!insync) begin
                        if ($urandom_range(99) >= 10) v = stk_pkg::B_INSYNC;
                    end else if (bad || (doom_sync && cmd == stk_pkg::C_SYNC && !on_sec)) begin
                        v = stk_pkg::B_OK ^ 8'($urandom_range(1, 255));
                    end else begin
                        v = stk_pkg::B_OK;
                    end
                end
                stk_pkg::PH_RD_INSYNC: if ($urandom_range(99) >= 4) begin
                    k = stk_pkg::K_RX;
                    v = bad ? stk_pkg::B_INSYNC ^ 8'($urandom_range(1, 255)) : stk_pkg::B_INSYNC;
                end
                stk_pkg::PH_RD_DATA: if ($urandom_range(99) >= 2) begin
                    k = stk_pkg::K_RX;
                    v = bad ? pbuf[cmp_idx] ^ 8'($urandom_range(1, 255)) : pbuf[cmp_idx];
                end
                stk_pkg::PH_RD_OK: if ($urandom_range(99) >= 4) begin
                    k = stk_pkg::K_RX;
                    v = bad ? stk_pkg::B_OK ^ 8'($urandom_range(1, 255)) : stk_pkg::B_OK;
                end
                default: k = stk_pkg::K_TICK;
            endcase
            send_item(k, v);
            n++;
            rand_items++;
        end
    endtask

    initial begin
        t_row plan [$];
        t_ev baud0, rst1;
        int pm [4];
        int len, cap;
        pm = '{0, 1, 3, 8};
        in_ch.valid <= 1'b0;
        in_ch.kind  <= stk_pkg::K_TICK;
        in_ch.value <= 8'h00;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        foreach (fin_seen[i]) fin_seen[i] = 0;
        cfg_len = 15'd1; cfg_tmo = 12'd500; cfg_sec = 1'b1;
        ph = stk_pkg::PH_IDLE; cmd = stk_pkg::C_SYNC;
        img_off = 0; fill_cnt = 0; pg_len = 0; cmd_idx = 0; cmp_idx = 0;
        wtimer = 0; tries = 0; insync = 0; on_sec = 0; rst_lvl = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        baud0 = '{ev: stk_pkg::E_BAUD, b: 8'h00, rst: 1'b0, baud: 1'b0, st: stk_pkg::ST_OK,
                  off: 15'd0};
        rst1  = '{ev: stk_pkg::E_RST,  b: 8'h00, rst: 1'b1, baud: 1'b0, st: stk_pkg::ST_OK,
                  off: 15'd0};
        // stray events out of reset, then start, restart and the reset pulse
        plan.push_back('{stk_pkg::K_TX, 8'h00, 1'b0, '0});
        plan.push_back('{stk_pkg::K_IMG, 8'hA5, 1'b0, '0});
        plan.push_back('{stk_pkg::K_RX, stk_pkg::B_INSYNC, 1'b0, '0});
        plan.push_back('{stk_pkg::K_TICK, 8'h00, 1'b0, '0});
        plan.push_back('{3'd5, 8'hFF, 1'b0, '0});
        plan.push_back('{3'd7, 8'h00, 1'b0, '0});
        plan.push_back('{stk_pkg::K_START, 8'h00, 1'b1, baud0});
        plan.push_back('{stk_pkg::K_TX, 8'h55, 1'b0, '0});
        plan.push_back('{stk_pkg::K_RX, 8'hFF, 1'b0, '0});
        repeat (4) plan.push_back('{stk_pkg::K_TICK, 8'h00, 1'b0, '0});
        plan.push_back('{stk_pkg::K_TICK, 8'h00, 1'b1, rst1});
        plan.push_back('{stk_pkg::K_START, 8'hFF, 1'b1, baud0});
        plan.push_back('{3'd6, 8'h5A, 1'b0, '0});
        repeat (4) plan.push_back('{stk_pkg::K_TICK, 8'hFF, 1'b0, '0});
        plan.push_back('{stk_pkg::K_TICK, 8'h00, 1'b1, rst1});
        plan.push_back('{stk_pkg::K_IMG, 8'h00, 1'b0, '0});
        foreach (plan[i]) send_item(plan[i].kind, plan[i].value, plan[i].typed, plan[i].want);

        calm = 1'b1;
        run_session(0, 4095, 1'b0, 0, 1'b0, 3000);
        calm = 1'b0;
        run_session(3, 300, 1'b1, 0, 1'b1, 3000);
        run_session(2, 300, 1'b0, 0, 1'b1, 3000);
        while (rand_items < 1750) begin
            cap = 3000;
            case ($urandom_range(4))
                0, 1: len = $urandom_range(0, 40);
                2: len = $urandom_range(stk_pkg::PAGE_BYTES_DEF - 1,
                                        stk_pkg::PAGE_BYTES_DEF + 1);
                3: len = $urandom_range(1, 4);
                default: begin len = 30720; cap = 600; end
            endcase
            run_session(len, $urandom_range(3) == 0 ? $urandom_range(1, 8) :
                        $urandom_range(100, 4095), 1'($urandom), pm[$urandom_range(3)],
                        1'b0, cap);
        end

        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_events.size() != 0) errors += pending_events.size();
        $display("%0d sessions, %0d input beats, %0d result beats checked, %0d mismatches",
                 sessions, items, checked, errors);
        $display("finish status counts ok/nosync/progref/wrfail/vfyfail: %0d %0d %0d %0d %0d",
                 fin_seen[0], fin_seen[1], fin_seen[2], fin_seen[3], fin_seen[4]);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
